[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion checked on every rising clock edge
`define ASSERT_AT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// concurrent assertion switched off while reset is high
`define ASSERT_AT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

[rtl/ldh_pkg.sv]
// ---------------------------------------------------------------------------
// ldh_pkg
// shared types and register codes of the horizontal line dilation unit
// ---------------------------------------------------------------------------
`default_nettype none

package ldh_pkg;

   localparam int PIXEL_W = 8;

   typedef logic [PIXEL_W-1:0] pixel_type;

   // register index = paddr[3:2]
   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      REG_SE_SIZE    = 2'd0,
      REG_LINE_WIDTH = 2'd1,
      REG_LINE_COUNT = 2'd2
   } csr_reg_type;

   localparam int SE_SIZE_W    = 7;
   localparam int LINE_WIDTH_W = 11;
   localparam int LINE_COUNT_W = 11;

   localparam logic [SE_SIZE_W-1:0]    SE_SIZE_RST    = 7'd3;
   localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 11'd1024;
   localparam logic [LINE_COUNT_W-1:0] LINE_COUNT_RST = 11'd1024;

endpackage

`default_nettype wire

[rtl/ldh_window.sv]
// ---------------------------------------------------------------------------
// ldh_window
// running maximum line: entry a holds the maximum of the last a+1 pixels,
// one entry is selected as the dilated output
// ---------------------------------------------------------------------------
`default_nettype none

module ldh_window #(
   parameter int MAX_SE = 64
) (
   input  logic                                         clock,
   input  logic                                         shift_en,
   input  ldh_pkg::pixel_type                           pixel_in,
   input  logic [$clog2(MAX_SE > 1 ? MAX_SE : 2)-1:0]   tap_sel,
   output ldh_pkg::pixel_type                           tap_out
);
   import ldh_pkg::*;

   pixel_type run_max_ff [MAX_SE];

   always_ff @(posedge clock) begin
      if (shift_en) begin
         run_max_ff[0] <= pixel_in;
         for (int a = 1; a < MAX_SE; a++) begin
            run_max_ff[a] <= (run_max_ff[a-1] > pixel_in) ? run_max_ff[a-1] : pixel_in;
         end
      end
   end

   // selected entry never lies beyond the current column, so older rows never leak in
   assign tap_out = run_max_ff[tap_sel];

endmodule

`default_nettype wire

[rtl/line_dilation_horizontal_unit.sv]
// Result path: accepted item to the job registers, then its result to the rsp result register;
// output pixel p of a row waits for input pixel p+se_size/2 or for the row end.
// Throughput: one pixel per cycle while rsp_ready is high; after the last pixel of a row,
// input waits while the window unit flushes the rest of the row.
// Reset (synchronous, active high): se_size 3, line_width 1024, line_count 1024,
// position at the start of a frame, no result pending.
// ---------------------------------------------------------------------------
// line_dilation_horizontal_unit
// grayscale dilation of a raster pixel stream by a horizontal segment
// ---------------------------------------------------------------------------
`default_nettype none

module line_dilation_horizontal_unit #(
   parameter int MAX_SE    = 64,
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_LINES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ldh_pkg::pixel_type                req_pixel_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ldh_pkg::pixel_type                rsp_pixel_out,
   output logic                              rsp_row_end,
   output logic                              rsp_frame_end,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ldh_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import ldh_pkg::*;

   localparam int SW = $clog2(MAX_SE + 1);
   localparam int IW = $clog2(MAX_SE > 1 ? MAX_SE : 2);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int LW = $clog2(MAX_LINES > 1 ? MAX_LINES : 2);
   localparam int HW = $clog2(MAX_LINES + 1);
   localparam int RW = $clog2(MAX_WIDTH + MAX_SE);
   localparam int NW = $clog2(MAX_SE / 2 + 2);

   // configuration
   logic [SE_SIZE_W-1:0]    se_size_ff, se_size_in;
   logic [LINE_WIDTH_W-1:0] line_width_ff, line_width_in;
   logic [LINE_COUNT_W-1:0] line_count_ff, line_count_in;
   logic [1:0]              csr_idx;
   logic                    csr_wr;
   logic                    csr_hit;

   // position
   logic [CW-1:0] col_ff, col_in;
   logic [LW-1:0] row_ff, row_in;

   // pending results of the current item
   logic          job_busy_ff, job_busy_in;
   logic [RW-1:0] job_reach_ff, job_reach_in;
   logic [CW-1:0] job_col_ff, job_col_in;
   logic [NW-1:0] job_cnt_ff, job_cnt_in;
   logic          job_last_ff, job_last_in;
   logic          job_last_row_ff, job_last_row_in;

   // result register
   logic      rsp_valid_ff, rsp_valid_in;
   pixel_type rsp_pixel_ff, rsp_pixel_in;
   logic      rsp_row_end_ff, rsp_row_end_in;
   logic      rsp_frame_end_ff, rsp_frame_end_in;

   logic [SW-1:0] se_eff, se_mid, se_left;
   logic [WW-1:0] width_eff;
   logic [HW-1:0] count_eff;
   logic          row_last, frame_last_row, col_ge_mid;
   logic [RW-1:0] reach_start;
   logic [NW-1:0] result_cnt;
   logic          req_fire, emit, job_done;
   logic [IW-1:0] tap_sel;
   pixel_type     tap_out;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      se_size_in    = se_size_ff;
      line_width_in = line_width_ff;
      line_count_in = line_count_ff;
      csr_hit       = 1'b0;
      csr_prdata    = '0;
      unique case (csr_idx)
         REG_SE_SIZE: begin
            csr_prdata = 32'(se_size_ff);
            if (csr_wr) begin
               se_size_in = csr_pwdata[SE_SIZE_W-1:0];
               csr_hit    = 1'b1;
            end
         end
         REG_LINE_WIDTH: begin
            csr_prdata = 32'(line_width_ff);
            if (csr_wr) begin
               line_width_in = csr_pwdata[LINE_WIDTH_W-1:0];
               csr_hit       = 1'b1;
            end
         end
         REG_LINE_COUNT: begin
            csr_prdata = 32'(line_count_ff);
            if (csr_wr) begin
               line_count_in = csr_pwdata[LINE_COUNT_W-1:0];
               csr_hit       = 1'b1;
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // clipped register values
   always_comb begin
      if (se_size_ff == '0) begin
         se_eff = SW'(1);
      end else if (32'(se_size_ff) > MAX_SE) begin
         se_eff = SW'(MAX_SE);
      end else begin
         se_eff = SW'(se_size_ff);
      end
      if (line_width_ff == '0) begin
         width_eff = WW'(1);
      end else if (32'(line_width_ff) > MAX_WIDTH) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(line_width_ff);
      end
      if (line_count_ff == '0) begin
         count_eff = HW'(1);
      end else if (32'(line_count_ff) > MAX_LINES) begin
         count_eff = HW'(MAX_LINES);
      end else begin
         count_eff = HW'(line_count_ff);
      end
   end

   assign se_mid         = se_eff >> 1;
   assign se_left        = se_eff - SW'(1) - se_mid;
   assign row_last       = (32'(col_ff) + 32'd1) >= 32'(width_eff);
   assign frame_last_row = (32'(row_ff) + 32'd1) >= 32'(count_eff);
   assign col_ge_mid     = 32'(col_ff) >= 32'(se_mid);

   // reach = how far back the window of the first result goes, in pixels
   always_comb begin
      if (col_ge_mid) begin
         reach_start = RW'(se_eff - SW'(1));
      end else begin
         reach_start = RW'(32'(col_ff) + 32'(se_left));
      end
      if (row_last) begin
         result_cnt = col_ge_mid ? NW'(32'(se_mid) + 32'd1) : NW'(32'(col_ff) + 32'd1);
      end else begin
         result_cnt = col_ge_mid ? NW'(1) : NW'(0);
      end
   end

   assign emit      = job_busy_ff && (!rsp_valid_ff || rsp_ready);
   assign job_done  = emit && (job_cnt_ff == NW'(1));
   assign req_ready = !job_busy_ff || job_done;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (req_fire) begin
         if (row_last) begin
            col_in = '0;
            row_in = frame_last_row ? '0 : LW'(32'(row_ff) + 32'd1);
         end else begin
            col_in = CW'(32'(col_ff) + 32'd1);
         end
      end
   end

   always_comb begin
      job_busy_in     = job_busy_ff;
      job_reach_in    = job_reach_ff;
      job_col_in      = job_col_ff;
      job_cnt_in      = job_cnt_ff;
      job_last_in     = job_last_ff;
      job_last_row_in = job_last_row_ff;
      priority if (req_fire) begin
         job_busy_in     = (result_cnt != '0);
         job_reach_in    = reach_start;
         job_col_in      = col_ff;
         job_cnt_in      = result_cnt;
         job_last_in     = row_last;
         job_last_row_in = frame_last_row;
      end else if (job_done) begin
         job_busy_in = 1'b0;
      end else if (emit) begin
         job_cnt_in   = job_cnt_ff - NW'(1);
         job_reach_in = job_reach_ff - RW'(1);
      end
   end

   // window clipped at the row start
   assign tap_sel = (32'(job_reach_ff) < 32'(job_col_ff)) ? IW'(job_reach_ff) : IW'(job_col_ff);

   ldh_window #(
      .MAX_SE (MAX_SE)
   ) u_window (
      .clock    (clock),
      .shift_en (req_fire),
      .pixel_in (req_pixel_in),
      .tap_sel  (tap_sel),
      .tap_out  (tap_out)
   );

   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_pixel_in     = rsp_pixel_ff;
      rsp_row_end_in   = rsp_row_end_ff;
      rsp_frame_end_in = rsp_frame_end_ff;
      if (emit) begin
         rsp_valid_in     = 1'b1;
         rsp_pixel_in     = tap_out;
         rsp_row_end_in   = job_last_ff && (job_cnt_ff == NW'(1));
         rsp_frame_end_in = job_last_ff && job_last_row_ff && (job_cnt_ff == NW'(1));
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         se_size_ff    <= SE_SIZE_RST;
         line_width_ff <= LINE_WIDTH_RST;
         line_count_ff <= LINE_COUNT_RST;
         col_ff        <= '0;
         row_ff        <= '0;
         job_busy_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         se_size_ff    <= se_size_in;
         line_width_ff <= line_width_in;
         line_count_ff <= line_count_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         job_busy_ff   <= job_busy_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_reach_ff     <= job_reach_in;
      job_col_ff       <= job_col_in;
      job_cnt_ff       <= job_cnt_in;
      job_last_ff      <= job_last_in;
      job_last_row_ff  <= job_last_row_in;
      rsp_pixel_ff     <= rsp_pixel_in;
      rsp_row_end_ff   <= rsp_row_end_in;
      rsp_frame_end_ff <= rsp_frame_end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_row_end   = rsp_row_end_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

endmodule

`default_nettype wire

[rtl/ldh_checker.sv]
// ---------------------------------------------------------------------------
// ldh_checker
// port-level checks of the horizontal line dilation unit
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ldh_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_row_end,
   input logic rsp_frame_end,
   input logic csr_pready
);

   // a stalled result stays offered
   `ASSERT_AT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")

   // the frame ends only on the last pixel of a row
   `ASSERT_AT_RST(a_frame_row, clock, reset, rsp_valid && rsp_frame_end |-> rsp_row_end, "frame end without row end")

   // no result straight out of reset
   `ASSERT_AT(a_reset_idle, clock, reset |=> !rsp_valid, "result valid after reset")

   // config port never waits
   `ASSERT_AT_RST(a_pready, clock, reset, csr_pready, "pready low")

endmodule

bind line_dilation_horizontal_unit ldh_checker u_ldh_checker (.*);

`default_nettype wire
